@@ rtl/slt_pkg.sv @@
package slt_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int VALUE_W      = 32;
  localparam int IDX_W        = 6;
  localparam int CNT_OUT_W    = 7;

  localparam logic [1:0] KIND_INSERT    = 2'd0;
  localparam logic [1:0] KIND_INSERT_UQ = 2'd1;
  localparam logic [1:0] KIND_READ      = 2'd2;
  localparam logic [1:0] KIND_REMOVE    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          index;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]      count;
    logic [1:0]                status;
  } rsp_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic                      ins_en;
    logic                      rem_en;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          index;
  } cell_ctrl_t;

endpackage

@@ rtl/slt_cell.sv @@
module slt_cell import slt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int POS      = 0
) (
  input  logic                      clk,
  input  cell_ctrl_t                ctrl,
  input  logic [$clog2(CAPACITY+1)-1:0] count,
  input  logic                      left_after,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic signed [VALUE_W-1:0] right_entry,
  output logic                      after,
  output logic                      eq,
  output logic signed [VALUE_W-1:0] entry,
  output logic signed [VALUE_W-1:0] rd_data
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam bit READABLE = (POS < (1 << IDX_W));

  logic occupied;
  logic rd_sel;
  logic rem_sel;

  assign occupied = (count > CW'(POS));
  // Empty slots count as "at or after" the insertion point
  assign after    = !occupied || (entry >= ctrl.value);
  assign eq       = occupied && (entry == ctrl.value);

  assign rd_sel  = READABLE && occupied && (int'(ctrl.index) == POS);
  assign rem_sel = (int'(ctrl.index) <= POS);
  assign rd_data = rd_sel ? entry : '0;

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (after && !left_after) begin
        entry <= ctrl.value;
      end else if (after) begin
        entry <= left_entry;
      end
    end else if (ctrl.rem_en && rem_sel) begin
      entry <= right_entry;
    end
  end

endmodule

@@ rtl/sorted_list_table.sv @@
// Sorted list table: keeps signed 32-bit values in ascending order in a row
// of CAPACITY cells, one value per cell.
// Request channel (req_valid / req_stall / req): each request carries a kind
// (insert, insert unique, read at index, remove at index), a value and an
// index. Response channel (rsp_valid / rsp_stall / rsp): one response per
// request with the value read, the entry count after the request and a status
// (ok, full, duplicate ignored, index out of range).
// Every cell compares its entry to the request value at once, and all cells
// shift left or right together on the same edge, so each request is applied
// on the edge that accepts it: the response is registered and appears the cycle after accept.
// Throughput is one request per cycle while the response side keeps up.
// When the receiver stalls, the response holds in its register and
// req_stall rises until it is taken; no request is dropped.
// Reset (synchronous, active high) empties the table and drops any pending
// response; cell contents are not cleared, since only occupied cells are read.
module sorted_list_table import slt_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(CAPACITY+1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  cell_ctrl_t        ctrl;
  logic              dup;
  logic              full;
  logic              in_range;
  logic              is_ins;
  logic              is_rem;
  logic              is_rd;
  logic signed [VALUE_W-1:0] rd_value;
  logic [1:0]        status;

  logic [CAPACITY-1:0] after;
  logic [CAPACITY-1:0] eq;
  logic signed [VALUE_W-1:0] entry   [CAPACITY];
  logic signed [VALUE_W-1:0] rd_data [CAPACITY];

  // Hold requests while a response waits to be taken
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign dup      = |eq;
  assign full     = (count == CW'(CAPACITY));
  assign in_range = (XW'(req.index) < XW'(count));
  assign is_ins   = (req.kind == KIND_INSERT) || (req.kind == KIND_INSERT_UQ);
  assign is_rd    = (req.kind == KIND_READ);
  assign is_rem   = (req.kind == KIND_REMOVE);

  always_comb begin
    status = ST_OK;
    case (req.kind)
      KIND_INSERT:    status = full ? ST_FULL : ST_OK;
      KIND_INSERT_UQ: status = dup ? ST_DUP : (full ? ST_FULL : ST_OK);
      KIND_READ:      status = in_range ? ST_OK : ST_RANGE;
      KIND_REMOVE:    status = in_range ? ST_OK : ST_RANGE;
      default:        status = ST_OK;
    endcase
  end

  assign ctrl.ins_en = accept && is_ins && (status == ST_OK);
  assign ctrl.rem_en = accept && is_rem && (status == ST_OK);
  assign ctrl.value  = req.value;
  assign ctrl.index  = req.index;

  always_comb begin
    count_next = count;
    if (ctrl.ins_en) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem_en) begin
      count_next = count - CW'(1);
    end
  end

  // Each cell drives zero unless it is the addressed one: OR them together
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_value = rd_value | rd_data[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                      l_after;
    logic signed [VALUE_W-1:0] l_entry;
    logic signed [VALUE_W-1:0] r_entry;

    if (g == 0) begin : g_head
      assign l_after = 1'b0;
      assign l_entry = '0;
    end else begin : g_body
      assign l_after = after[g-1];
      assign l_entry = entry[g-1];
    end

    if (g == CAPACITY-1) begin : g_tail
      assign r_entry = '0;
    end else begin : g_mid
      assign r_entry = entry[g+1];
    end

    slt_cell #(
      .CAPACITY (CAPACITY),
      .POS      (g)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .left_after  (l_after),
      .left_entry  (l_entry),
      .right_entry (r_entry),
      .after       (after[g]),
      .eq          (eq[g]),
      .entry       (entry[g]),
      .rd_data     (rd_data[g])
    );
  end

  // Advance the count and capture the response on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= (is_rd && in_range) ? rd_value : '0;
      rsp.count      <= CNT_OUT_W'(count_next);
      rsp.status     <= status;
    end
  end

endmodule
